// ===== hw/rtl/fns_pkg.sv =====
// fns_pkg: shared types and constants of the fact novelty scorer
// used by fns_back and fact_novelty_scorer; no dependencies
`default_nettype none
package fns_pkg;
    localparam int CFG_WIDTH = 16;
    localparam int SCORE_WIDTH = 27;
    localparam logic [26:0] SUM_MAX = 27'h7FFFFFF;
    localparam logic [26:0] SCORE_MAX = 27'd134215680;

    // fact table size, fixed by the 12-bit fact index
    localparam int FACT_SLOTS = 4096;
    localparam int SLOT_BITS = 12;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_VARS = 2'd2;

    localparam logic [1:0] MODE_BASIC = 2'd0;
    localparam logic [1:0] MODE_NOVEL = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;
    localparam logic [1:0] MODE_AGGR = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] weight;
        logic [10:0] vars;
    } cfg_t;
endpackage
`default_nettype wire

// ===== hw/rtl/fact_novelty_scorer.sv =====
// fact_novelty_scorer: top level, front queue, back end and configuration
// depends on fns_pkg, fns_front, fns_back, fns_div
`default_nettype none
// Scores search states fact by fact. After reset a clearing pass over all
// FACT_SLOTS entries empties the fact table; facts wait in the input queue
// meanwhile. Each fact then passes the back end in steps (table read, compare,
// write, sum); in aggregate mode a better or worse fact on a filled entry of a
// live state with a nonzero largest value also waits for the bit-serial divider,
// and a final fact adds the score step. The fact table read-modify-write sets the base rate.
module fact_novelty_scorer #(
    parameter int VALUE_BITS = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [11:0] fact_index,
    input  wire logic [19:0] h_value,
    input  wire logic        value_infinite,
    input  wire logic        last_fact,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [26:0]      novelty_score,
    output logic             dead_flag
);
    localparam int SLOT_BITS = fns_pkg::SLOT_BITS;
    fns_pkg::cfg_t cfg_reg;
    logic q_valid, q_ready;
    logic [SLOT_BITS+VALUE_BITS+1:0] q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= fns_pkg::MODE_BOTH;
            cfg_reg.weight <= 16'd1;
            cfg_reg.vars <= 11'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fns_pkg::CFG_MODE:   cfg_reg.mode <= cfg_data[1:0];
                fns_pkg::CFG_WEIGHT: cfg_reg.weight <= cfg_data;
                fns_pkg::CFG_VARS:   cfg_reg.vars <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    fns_front #(.SLOT_BITS(SLOT_BITS), .VALUE_BITS(VALUE_BITS), .DEPTH_BITS(2)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .fact_index(fact_index), .h_value(h_value),
        .value_infinite(value_infinite), .last_fact(last_fact),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    fns_back #(.SLOT_BITS(SLOT_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .out_valid(out_valid), .out_ready(out_ready),
        .novelty_score(novelty_score), .dead_flag(dead_flag)
    );

    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dead_flag |-> novelty_score == '0) else $error("dead end score");
    a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> novelty_score <= fns_pkg::SCORE_MAX) else $error("score range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(novelty_score))
        else $error("result dropped");
endmodule
`default_nettype wire

// ===== hw/rtl/fns_front.sv =====
// fns_front: accepts facts, masks fields and queues them for the back end
// no package dependency; a small fifo decouples the two sides
`default_nettype none
module fns_front #(
    parameter int SLOT_BITS = 12,
    parameter int VALUE_BITS = 20,
    parameter int DEPTH_BITS = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [11:0]           fact_index,
    input  wire logic [19:0]           h_value,
    input  wire logic                  value_infinite,
    input  wire logic                  last_fact,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output logic [SLOT_BITS+VALUE_BITS+1:0] q_data
);
    localparam int W = SLOT_BITS + VALUE_BITS + 2;
    localparam int DEPTH = 1 << DEPTH_BITS;
    logic [W-1:0] mem_reg [DEPTH];
    logic [DEPTH_BITS:0] wr_reg, rd_reg;
    logic [SLOT_BITS-1:0] slot;
    logic [VALUE_BITS-1:0] hv;
    logic push, pop;

    always_comb
    begin
        slot = '0;
        hv = '0;
        for (int i = 0; i < SLOT_BITS; i++)
            if (i < 12) slot[i] = fact_index[i];
        for (int i = 0; i < VALUE_BITS; i++)
            if (i < 20) hv[i] = h_value[i];
    end

    assign in_ready = (wr_reg - rd_reg) != (DEPTH_BITS+1)'(DEPTH);
    assign q_valid = wr_reg != rd_reg;
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;
    assign q_data = mem_reg[rd_reg[DEPTH_BITS-1:0]];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg[DEPTH_BITS-1:0]] <= {slot, hv, value_infinite, last_fact};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/fns_div.sv =====
// fns_div: restoring divider, one quotient bit per cycle
// no package dependency
`default_nettype none
module fns_div #(
    parameter int NUM_BITS = 36,
    parameter int DEN_BITS = 20
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     done,
    output logic [NUM_BITS-1:0]      quot
);
    localparam int CW = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] q_reg;
    logic [DEN_BITS:0] r_reg;
    logic [DEN_BITS-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg;
    logic [DEN_BITS:0] trial;

    assign trial = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
    assign quot = q_reg;
    assign done = busy_reg && cnt_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= CW'(NUM_BITS);
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NUM_BITS-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/fns_back.sv =====
// fns_back: table read-modify-write and sums per fact, score per state
// depends on fns_pkg and fns_div
`default_nettype none
module fns_back #(
    parameter int SLOT_BITS = 12,
    parameter int VALUE_BITS = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire fns_pkg::cfg_t         cfg,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire logic [SLOT_BITS+VALUE_BITS+1:0] q_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [26:0]                novelty_score,
    output logic                       dead_flag
);
    localparam int SLOTS = 1 << SLOT_BITS;
    localparam int NB = VALUE_BITS + 16;
    localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_READ = 3'd2,
                           S_EVAL = 3'd3, S_DIV = 3'd4, S_ADD = 3'd5,
                           S_SCORE = 3'd6;

    // entry: valid bit above the value
    logic [VALUE_BITS:0] table_mem [SLOTS];
    logic [VALUE_BITS:0] rd_reg;
    logic [2:0] state_reg;
    logic [SLOT_BITS:0] clr_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [VALUE_BITS-1:0] h_reg, lg_reg, diff_reg;
    logic lg_valid_reg, inf_reg, last_reg, better_reg, worse_reg;
    logic [26:0] bsum_reg, wsum_reg, add_reg;
    logic [26:0] score_reg;
    logic dead_reg, out_valid_reg;
    logic [31:0] prod_reg;
    logic div_start, div_done;
    logic [NB-1:0] div_q;
    logic [27:0] bsum_add, wsum_add;
    logic [29:0] r_val;
    logic st_inf, ent_valid;
    logic [VALUE_BITS-1:0] ent;

    // a waiting result only holds back a final fact in S_SCORE
    assign q_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign novelty_score = score_reg;
    assign dead_flag = dead_reg;
    assign ent_valid = rd_reg[VALUE_BITS];
    assign ent = rd_reg[VALUE_BITS-1:0];
    assign st_inf = inf_reg;
    assign div_start = state_reg == S_EVAL && !st_inf && ent_valid
                       && cfg.mode == fns_pkg::MODE_AGGR && (better_reg || worse_reg)
                       && lg_valid_reg && lg_reg != '0;
    assign bsum_add = {1'b0, bsum_reg} + {1'b0, add_reg};
    assign wsum_add = {1'b0, wsum_reg} + {1'b0, add_reg};

    fns_div #(.NUM_BITS(NB), .DEN_BITS(VALUE_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(NB'(cfg.weight) * NB'(diff_reg)), .den(lg_reg),
        .done(div_done), .quot(div_q)
    );

    // final score from registered product and sums, or a 0/1 flag in basic mode
    always_comb
    begin
        r_val = '0;
        if (cfg.mode == fns_pkg::MODE_BASIC)
            r_val = (bsum_reg != '0) ? 30'd0 : 30'd1;
        else if (cfg.mode == fns_pkg::MODE_NOVEL || bsum_reg != '0)
            r_val = {1'b0, prod_reg[28:0]} - {3'b0, bsum_reg};
        else
            r_val = {1'b0, prod_reg[28:0]} + {3'b0, wsum_reg};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            table_mem[clr_reg[SLOT_BITS-1:0]] <= '0;
        else if (state_reg == S_EVAL && !st_inf && better_reg)
            table_mem[slot_reg] <= {1'b1, h_reg};
        // entry held until the next fact transfer
        if (q_valid && q_ready)
            rd_reg <= table_mem[q_data[VALUE_BITS+SLOT_BITS+1:VALUE_BITS+2]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            lg_valid_reg <= 1'b0;
            inf_reg <= 1'b0;
            bsum_reg <= '0;
            wsum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (SLOT_BITS+1)'(SLOTS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (q_valid && q_ready)
                    begin
                        slot_reg <= q_data[VALUE_BITS+SLOT_BITS+1:VALUE_BITS+2];
                        h_reg <= q_data[VALUE_BITS+1:2];
                        inf_reg <= inf_reg | q_data[1];
                        last_reg <= q_data[0];
                        state_reg <= S_READ;
                    end
                S_READ:
                begin
                    // raise largest in a live state before the divider uses it
                    if (!inf_reg && (!lg_valid_reg || h_reg > lg_reg))
                    begin
                        lg_reg <= h_reg;
                        lg_valid_reg <= 1'b1;
                    end
                    better_reg <= !ent_valid || ent > h_reg;
                    worse_reg <= ent_valid && ent < h_reg;
                    diff_reg <= (ent > h_reg) ? ent - h_reg : h_reg - ent;
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (better_reg && (!ent_valid || cfg.mode != fns_pkg::MODE_AGGR))
                        add_reg <= 27'(cfg.weight);
                    else if (worse_reg && cfg.mode == fns_pkg::MODE_BOTH)
                        add_reg <= 27'(cfg.weight);
                    else
                        add_reg <= '0;
                    state_reg <= div_start ? S_DIV : S_ADD;
                end
                S_DIV:
                    if (div_done)
                    begin
                        // diff never exceeds largest, so the quotient fits the weight
                        add_reg <= 27'(div_q);
                        state_reg <= S_ADD;
                    end
                S_ADD:
                begin
                    if (!inf_reg && better_reg)
                        bsum_reg <= bsum_add[27] ? fns_pkg::SUM_MAX : bsum_add[26:0];
                    else if (!inf_reg && worse_reg)
                        wsum_reg <= wsum_add[27] ? fns_pkg::SUM_MAX : wsum_add[26:0];
                    prod_reg <= 32'(cfg.weight) * 32'(cfg.vars);
                    state_reg <= last_reg ? S_SCORE : S_IDLE;
                end
                S_SCORE:
                    if (!out_valid_reg)
                    begin
                        dead_reg <= inf_reg;
                        if (inf_reg || r_val[29])
                            score_reg <= '0;
                        else if (r_val[28:0] > 29'(fns_pkg::SCORE_MAX))
                            score_reg <= fns_pkg::SCORE_MAX;
                        else
                            score_reg <= r_val[26:0];
                        out_valid_reg <= 1'b1;
                        bsum_reg <= '0;
                        wsum_reg <= '0;
                        inf_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sim/fact_novelty_scorer_tb.sv =====
// fact_novelty_scorer_tb: self-checking testbench for the fact novelty scorer
// holds a novelty predictor with its own fact table and a queue of expected scores
// depends on fns_pkg and fact_novelty_scorer
`timescale 1ns / 1ps

typedef struct {
    logic [26:0] score;
    logic        dead;
} score_t;

class novelty_scoreboard;
    logic [19:0] best_h [4096];
    bit          best_ok [4096];
    logic [19:0] top_h;
    bit          top_ok;
    logic [27:0] better_acc;
    logic [27:0] worse_acc;
    bit          in_dead;
    logic [1:0]  mode;
    logic [15:0] weight;
    logic [10:0] vars;
    score_t      expected_scores[$];
    int          mismatches;

    function new();
        foreach (best_ok[i]) best_ok[i] = 0;
        top_ok = 0;
        top_h = '0;
        better_acc = '0;
        worse_acc = '0;
        in_dead = 0;
        mode = fns_pkg::MODE_BOTH;
        weight = 16'd1;
        vars = 11'd1;
        mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
        if (idx == fns_pkg::CFG_MODE)
            mode = data[1:0];
        else if (idx == fns_pkg::CFG_WEIGHT)
            weight = data;
        else if (idx == fns_pkg::CFG_VARS)
            vars = data[10:0];
    endfunction

    function logic [27:0] ratio(logic [19:0] diff);
        logic [35:0] prod;
        if (!top_ok || top_h == 0)
            return '0;
        prod = 36'(weight) * 36'(diff);
        return 28'(prod / 36'(top_h));
    endfunction

    function logic [27:0] sat(logic [27:0] a, logic [27:0] b);
        logic [28:0] s;
        s = 29'(a) + 29'(b);
        return (s > 29'(fns_pkg::SUM_MAX)) ? 28'(fns_pkg::SUM_MAX) : s[27:0];
    endfunction

    function void note_fact(logic [11:0] fi, logic [19:0] h, logic inf, logic last);
        logic [27:0] add;
        longint      base, r;
        score_t      e;
        if (inf)
            in_dead = 1;
        if (!in_dead) begin
            if (!top_ok || h > top_h) begin
                top_h = h;
                top_ok = 1;
            end
            if (!best_ok[fi] || best_h[fi] > h) begin
                if (!best_ok[fi] || mode != fns_pkg::MODE_AGGR)
                    add = 28'(weight);
                else
                    add = ratio(best_h[fi] - h);
                best_h[fi] = h;
                best_ok[fi] = 1;
                better_acc = sat(better_acc, add);
            end else if (best_h[fi] < h) begin
                add = '0;
                if (mode == fns_pkg::MODE_BOTH)
                    add = 28'(weight);
                else if (mode == fns_pkg::MODE_AGGR)
                    add = ratio(h - best_h[fi]);
                worse_acc = sat(worse_acc, add);
            end
        end
        if (!last)
            return;
        e.score = '0;
        e.dead = in_dead;
        if (!in_dead) begin
            base = longint'(weight) * longint'(vars);
            if (mode == fns_pkg::MODE_BASIC)
                r = (better_acc > 0) ? 0 : 1;
            else if (mode == fns_pkg::MODE_NOVEL || better_acc > 0)
                r = base - longint'(better_acc);
            else
                r = base + longint'(worse_acc);
            if (r < 0)
                r = 0;
            if (r > longint'(fns_pkg::SCORE_MAX))
                r = longint'(fns_pkg::SCORE_MAX);
            e.score = 27'(r);
        end
        expected_scores.insert(expected_scores.size(), e);
        better_acc = '0;
        worse_acc = '0;
        in_dead = 0;
    endfunction

    function void check_score(logic [26:0] score, logic dead);
        score_t e;
        if (expected_scores.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: score %0d dead_flag %0d", score, dead);
            return;
        end
        e = expected_scores.pop_front();
        if (score !== e.score || dead !== e.dead) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected score %0d dead_flag %0d, got score %0d dead_flag %0d",
                         e.score, e.dead, score, dead);
        end
    endfunction

    function int pending();
        return expected_scores.size();
    endfunction
endclass

module fact_novelty_scorer_tb;
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [11:0] fact_index;
    logic [19:0] h_value;
    logic        value_infinite;
    logic        last_fact;
    logic        out_valid;
    logic        out_ready;
    logic [26:0] novelty_score;
    logic        dead_flag;

    novelty_scoreboard sb;
    bit                calm;
    int                facts_sent;

    fact_novelty_scorer u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .fact_index      (fact_index),
        .h_value         (h_value),
        .value_infinite  (value_infinite),
        .last_fact       (last_fact),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .novelty_score   (novelty_score),
        .dead_flag       (dead_flag)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("fact_novelty_scorer regression: fail");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 0;
        sb.set_reg(idx, data);
    endtask

    // drop valid after the last transfer, then wait for every score
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (100) @(posedge clk);
    endtask

    task automatic send_fact(logic [11:0] fi, logic [19:0] h, logic inf, logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        fact_index = fi;
        h_value = h;
        value_infinite = inf;
        last_fact = last;
        in_valid = 1;
        do @(posedge clk); while (!in_ready);
        sb.note_fact(fi, h, inf, last);
        facts_sent++;
    endtask

    task automatic send_state(int len, bit wide);
        logic [19:0] h;
        logic [11:0] fi;
        int          dead_pos;
        case ($urandom_range(0, 2))
            0: h = 20'($urandom_range(0, 15));
            1: h = 20'($urandom_range(0, 1023));
            default: h = 20'($urandom);
        endcase
        dead_pos = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int k = 0; k < len; k++)
        begin
            fi = wide ? 12'($urandom) : 12'($urandom_range(0, 31));
            // a few broken states mix values within one state
            if ($urandom_range(0, 19) == 0)
                h = 20'($urandom);
            send_fact(fi, h, k == dead_pos, k == len - 1);
        end
    endtask

    task automatic run_random(int n_facts);
        int target;
        target = facts_sent + n_facts;
        while (facts_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
                calm = ~calm;
            send_state($urandom_range(1, 8), $urandom_range(0, 5) == 0);
        end
        calm = 0;
    endtask

    initial
    begin
        int gap;
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 8);
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready = 0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1;
            do @(posedge clk); while (!out_valid);
            sb.check_score(novelty_score, dead_flag);
        end
    end

    initial
    begin
        logic [1:0]  modes [9];
        logic [15:0] weights [9];
        logic [15:0] counts [9];
        modes = '{fns_pkg::MODE_BASIC, fns_pkg::MODE_NOVEL, fns_pkg::MODE_BOTH,
                  fns_pkg::MODE_AGGR, fns_pkg::MODE_AGGR, fns_pkg::MODE_NOVEL,
                  fns_pkg::MODE_BASIC, fns_pkg::MODE_BOTH, fns_pkg::MODE_AGGR};
        weights = '{16'd1, 16'd65535, 16'd300, 16'd65535, 16'd7, 16'd1, 16'd65535,
                    16'd65535, 16'd1000};
        counts = '{16'd1, 16'd1024, 16'd17, 16'd1024, 16'd1, 16'd1024, 16'd5, 16'd1024,
                   16'd100};
        sb = new();
        calm = 0;
        facts_sent = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = fns_pkg::CFG_MODE;
        cfg_data = '0;
        in_valid = 0;
        fact_index = '0;
        h_value = '0;
        value_infinite = 0;
        last_fact = 0;
        out_ready = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset settings: separate both
        send_fact(12'd0, 20'd0, 0, 1);
        send_fact(12'd4095, 20'hFFFFF, 0, 1);
        send_fact(12'd7, 20'd500, 0, 0);
        send_fact(12'd8, 20'd500, 0, 1);
        send_fact(12'd7, 20'd200, 0, 1);          // better on filled entry
        send_fact(12'd7, 20'd900, 0, 1);          // worse
        send_fact(12'd7, 20'd200, 0, 1);          // equal
        send_fact(12'd9, 20'd50, 1, 1);           // dead end, single fact
        send_fact(12'd10, 20'd60, 0, 0);
        send_fact(12'd11, 20'd60, 1, 0);          // dead end mid state
        send_fact(12'd12, 20'd60, 0, 1);
        wait_idle();
        write_reg(fns_pkg::CFG_MODE, 16'(fns_pkg::MODE_AGGR));
        write_reg(fns_pkg::CFG_WEIGHT, 16'd65535);
        send_fact(12'd7, 20'd100, 0, 1);
        send_fact(12'd7, 20'd1000, 0, 0);
        send_fact(12'd4095, 20'd3, 0, 1);
        send_fact(12'd8, 20'hFFFFF, 0, 1);
        wait_idle();

        for (int p = 0; p < 9; p++)
        begin
            write_reg(fns_pkg::CFG_MODE, 16'(modes[p]));
            write_reg(fns_pkg::CFG_WEIGHT, weights[p]);
            write_reg(fns_pkg::CFG_VARS, counts[p]);
            run_random(28);
            if (p == 4)
            begin
                wait_drained();
            end
            run_random(28);
            // one long state over many distinct facts
            if (p == 7)
            begin
                calm = 1;
                for (int k = 0; k < 200; k++)
                    send_fact(12'(k), 20'($urandom_range(0, 63)), 0, k == 199);
                calm = 0;
            end
            wait_idle();
        end

        @(negedge clk);
        in_valid = 0;
        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("fact_novelty_scorer regression: pass");
        else
            $display("fact_novelty_scorer regression: fail");
        $finish;
    end
endmodule
